// ----- src/dotted_version_string_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dotted version string parser
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DOTTED_VERSION_STRING_PARSER_DEFINES_SVH
`define DOTTED_VERSION_STRING_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DVSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvsp assertion failed");

// Next-cycle implication.
`define DVSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvsp assertion failed");

`else

`define DVSP_ASSERT_NOW(lbl, ante, cons)
`define DVSP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- src/dvsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Dotted version string parser package
// Field widths, character codes, status codes and the item and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package dvsp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned PART_W  = 31;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned NUM_FIN = 3;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CH_DOT  = 8'h2E;

  localparam logic [IDX_W-1:0] IDX_LAST = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_FORMAT = 2'd2
  } status_t;

  typedef struct packed {
    logic              present;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [PART_W-1:0]  major;
    logic [PART_W-1:0]  minor;
    logic [PART_W-1:0]  build;
    logic [PART_W-1:0]  revision;
    logic [COUNT_W-1:0] part_count;
  } result_t;

endpackage

`default_nettype wire

// ----- src/dvsp_input_reg.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one character item; stalls the sender only while a held last item
// cannot move into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvsp_input_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire dvsp_pkg::item_t item_in,
  input  wire logic           advance,
  output logic                in_stall,
  output logic                item_valid,
  output dvsp_pkg::item_t     item
);

  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (advance) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/dvsp_parse_core.sv -----
// ----------------------------------------------------------------------------
// Parse core
// Holds the accumulator, part index, finished parts and error flags, and
// forms the result of a last item in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dvsp_parse_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire dvsp_pkg::item_t item,
  output dvsp_pkg::result_t   res
);

  localparam int unsigned PW = dvsp_pkg::PART_W;
  localparam int unsigned NF = dvsp_pkg::NUM_FIN;

  logic [PW-1:0]                 accumulator, accumulator_next;
  logic                          overflow_seen, overflow_seen_next;
  logic                          part_empty, part_empty_next;
  logic                          format_bad, format_bad_next;
  logic [dvsp_pkg::IDX_W-1:0]    part_index, part_index_next;
  logic [PW-1:0]                 finished_parts [NF];
  logic [PW-1:0]                 finished_parts_next [NF];
  logic                          any_char_seen, any_char_seen_next;

  logic          is_digit;
  logic          is_dot;
  logic [3:0]    digit;
  logic [PW+3:0] product;
  logic          end_bad;

  assign is_digit = (item.ch >= dvsp_pkg::CH_ZERO) && (item.ch <= dvsp_pkg::CH_NINE);
  assign is_dot   = (item.ch == dvsp_pkg::CH_DOT);
  assign digit    = 4'(item.ch - dvsp_pkg::CH_ZERO);
  // Times ten as two shifted copies, plus the new digit.
  assign product  = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0}
                  + {{PW{1'b0}}, digit};

  // State after taking the character, if any.
  always_comb begin
    accumulator_next   = accumulator;
    overflow_seen_next = overflow_seen;
    part_empty_next    = part_empty;
    format_bad_next    = format_bad;
    part_index_next    = part_index;
    any_char_seen_next = any_char_seen;
    for (int i = 0; i < NF; i++) begin
      finished_parts_next[i] = finished_parts[i];
    end
    if (item.present) begin
      any_char_seen_next = 1'b1;
      if (is_digit) begin
        if (|product[PW+3:PW]) begin
          overflow_seen_next = 1'b1;
        end else begin
          accumulator_next = product[PW-1:0];
        end
        part_empty_next = 1'b0;
      end else if (is_dot) begin
        if (part_empty || overflow_seen || (part_index == dvsp_pkg::IDX_LAST)) begin
          format_bad_next = 1'b1;
        end
        if (part_index != dvsp_pkg::IDX_LAST) begin
          for (int i = 0; i < NF; i++) begin
            if (part_index == i[dvsp_pkg::IDX_W-1:0]) begin
              finished_parts_next[i] = accumulator;
            end
          end
          part_index_next = part_index + 1'b1;
        end
        accumulator_next   = '0;
        overflow_seen_next = 1'b0;
        part_empty_next    = 1'b1;
      end else begin
        format_bad_next = 1'b1;
      end
    end
  end

  // Result of a last item, from the updated state.
  assign end_bad = format_bad_next || part_empty_next || overflow_seen_next ||
                   (part_index_next == '0);

  always_comb begin
    res = '0;
    if (!any_char_seen_next) begin
      res.status = dvsp_pkg::STATUS_EMPTY;
    end else if (end_bad) begin
      res.status = dvsp_pkg::STATUS_FORMAT;
    end else begin
      res.status   = dvsp_pkg::STATUS_OK;
      // Entries past the current part are still zero, so they pass through.
      res.major    = finished_parts_next[0];
      res.minor    = (part_index_next == 2'd1) ? accumulator_next : finished_parts_next[1];
      res.build    = (part_index_next == 2'd2) ? accumulator_next : finished_parts_next[2];
      res.revision = (part_index_next == dvsp_pkg::IDX_LAST) ? accumulator_next : '0;
      res.part_count = {1'b0, part_index_next} + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && item.last)) begin
      accumulator   <= '0;
      overflow_seen <= 1'b0;
      part_empty    <= 1'b1;
      format_bad    <= 1'b0;
      part_index    <= '0;
      any_char_seen <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        finished_parts[i] <= '0;
      end
    end else if (fire) begin
      accumulator   <= accumulator_next;
      overflow_seen <= overflow_seen_next;
      part_empty    <= part_empty_next;
      format_bad    <= format_bad_next;
      part_index    <= part_index_next;
      any_char_seen <= any_char_seen_next;
      for (int i = 0; i < NF; i++) begin
        finished_parts[i] <= finished_parts_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/dvsp_result_reg.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dvsp_result_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire dvsp_pkg::result_t res_in,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output logic                  free,
  output dvsp_pkg::result_t     res
);

  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/dotted_version_string_parser.sv -----
// ----------------------------------------------------------------------------
// Dotted version string parser
// Parses "a.b[.c[.d]]" one character per transfer and reports the parts.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  present, ch, last
//   output   out        out_valid / out_stall status, major, minor, build,
//                                            revision, part_count
//
// One character transfer is taken every cycle while in_stall is low. A character
// is held in the input register; a last item's result is then loaded into the
// result register. The times-ten add and limit compare in the parse core are
// combinational.
// Reset (rst, synchronous) empties both registers and clears the parse state.
// A stalled result only holds back a last item; other characters keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dotted_version_string_parser_defines.svh"

module dotted_version_string_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Character input channel.
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           present,
  input  wire logic [dvsp_pkg::CHAR_W-1:0]    ch,
  input  wire logic                           last,
  // Result output channel.
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          status,
  output logic [dvsp_pkg::PART_W-1:0]         major,
  output logic [dvsp_pkg::PART_W-1:0]         minor,
  output logic [dvsp_pkg::PART_W-1:0]         build,
  output logic [dvsp_pkg::PART_W-1:0]         revision,
  output logic [dvsp_pkg::COUNT_W-1:0]        part_count
);

  dvsp_pkg::item_t   item_in;
  dvsp_pkg::item_t   item;
  dvsp_pkg::result_t core_res;
  dvsp_pkg::result_t res;
  logic              item_valid;
  logic              advance;
  logic              fire;
  logic              free;

  assign item_in.present = present;
  assign item_in.ch      = ch;
  assign item_in.last    = last;

  // The held item moves on unless it is a last item and the result register
  // is still occupied by a result the receiver has not taken.
  assign advance = !item_valid || !item.last || free;
  assign fire    = item_valid && advance;

  dvsp_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .item_in    (item_in),
    .advance    (advance),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  dvsp_parse_core u_parse_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (core_res)
  );

  dvsp_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && item.last),
    .res_in    (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (free),
    .res       (res)
  );

  assign status     = res.status;
  assign major      = res.major;
  assign minor      = res.minor;
  assign build      = res.build;
  assign revision   = res.revision;
  assign part_count = res.part_count;

  // The input side is only held back by a last item waiting on a full,
  // stalled result register.
  `DVSP_ASSERT_NOW(a_stall_cause, in_stall, item_valid && item.last && out_valid && out_stall)

  // A new result only comes from a last item that was processed.
  `DVSP_ASSERT_NEXT(a_result_source, !out_valid && !(fire && item.last), !out_valid)

  // A good string always has two to four parts.
  `DVSP_ASSERT_NOW(a_ok_count,
      out_valid && (res.status == dvsp_pkg::STATUS_OK),
      (part_count >= 3'd2) && (part_count <= 3'd4))

  // Any failure reports all-zero fields.
  `DVSP_ASSERT_NOW(a_err_zero,
      out_valid && (res.status != dvsp_pkg::STATUS_OK),
      (major == '0) && (minor == '0) && (build == '0) && (revision == '0) &&
      (part_count == '0))

endmodule

`default_nettype wire

// ----- bench/dotted_version_string_parser_test.sv -----
// ----------------------------------------------------------------------------
// Dotted version string parser testbench
// Streams version strings through the parser one character per transfer and
// checks every result against a predictor that tracks the parse state. The
// run opens with hand-picked strings and then sends random strings, mostly
// well-formed ones, under several patterns of sender idling and receiver stall.
// ----------------------------------------------------------------------------

module dotted_version_string_parser_test;
  import dvsp_pkg::*;

  // A version string as a queue of bytes. Any byte value, NUL included, can be sent.
  typedef logic [CHAR_W-1:0] text_t[$];

  // Number of cycles that the receiver holds off results in the pressure phase.
  localparam int HOLD_CYCLES = 400;

  // ---------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the parse state, works out the result
  // that each string should produce when its end transfer is taken, and
  // compares the results that leave the block in order.
  // ---------------------------------------------------------------------------
  class version_checker;
    localparam longint unsigned PART_LIMIT = 64'd2147483647;

    result_t           expected_versions[$];
    int                mismatches;
    int                ok_seen;
    int                empty_seen;
    int                format_seen;

    logic [PART_W-1:0] acc;
    bit                acc_over;
    bit                part_blank;
    bit                bad_format;
    bit                saw_char;
    logic [2:0]        part_idx;
    logic [PART_W-1:0] closed_parts[NUM_FIN];

    function new();
      restart();
    endfunction

    function void restart();
      acc        = '0;
      acc_over   = 1'b0;
      part_blank = 1'b1;
      bad_format = 1'b0;
      part_idx   = '0;
      saw_char   = 1'b0;
      foreach (closed_parts[i]) closed_parts[i] = '0;
    endfunction

    // Closing a part with a dot or with the end of the string is only legal
    // when the part has a digit and stayed within range.
    function void close_part();
      if (part_blank || acc_over) bad_format = 1'b1;
    endfunction

    function void absorb_byte(logic [CHAR_W-1:0] c);
      longint unsigned scaled;
      saw_char = 1'b1;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        scaled = 64'(acc) * 64'd10 + 64'(c - CH_ZERO);
        // On overflow the accumulator keeps its last in-range value.
        if (scaled > PART_LIMIT) acc_over = 1'b1;
        else acc = scaled[PART_W-1:0];
        part_blank = 1'b0;
      end else if (c == CH_DOT) begin
        close_part();
        if (part_idx >= NUM_FIN) begin
          bad_format = 1'b1;
        end else begin
          closed_parts[part_idx] = acc;
          part_idx++;
        end
        acc        = '0;
        acc_over   = 1'b0;
        part_blank = 1'b1;
      end else begin
        bad_format = 1'b1;
      end
    endfunction

    // Called for every accepted input transfer.
    function void note_transfer(logic p, logic [CHAR_W-1:0] c, logic l);
      result_t           want;
      logic [PART_W-1:0] vals[4];
      if (p) absorb_byte(c);
      if (!l) return;
      want = '0;
      foreach (vals[i]) vals[i] = '0;
      if (!saw_char) begin
        want.status = STATUS_EMPTY;
      end else begin
        close_part();
        if (part_idx == 0) bad_format = 1'b1;
        if (bad_format) begin
          want.status = STATUS_FORMAT;
        end else begin
          want.status = STATUS_OK;
          for (int i = 0; i < part_idx; i++) vals[i] = closed_parts[i];
          vals[part_idx]  = acc;
          want.major      = vals[0];
          want.minor      = vals[1];
          want.build      = vals[2];
          want.revision   = vals[3];
          want.part_count = part_idx + 3'd1;
        end
      end
      expected_versions.insert(expected_versions.size(), want);
      restart();
    endfunction

    // Every mismatch is counted; printing stops after the first fifty so that a
    // badly broken block does not flood the log.
    task report(string msg);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Called for every accepted result transfer.
    task check_version(result_t got);
      result_t want;
      if (expected_versions.size() == 0) begin
        report($sformatf("result with none expected (status %0d, part_count %0d)",
                         got.status, got.part_count));
        return;
      end
      want = expected_versions.pop_front();
      case (want.status)
        STATUS_OK:    ok_seen++;
        STATUS_EMPTY: empty_seen++;
        default:      format_seen++;
      endcase
      if (got.status != want.status)
        report($sformatf("status expected %0d, got %0d", want.status, got.status));
      if (got.major != want.major)
        report($sformatf("major expected %0d, got %0d", want.major, got.major));
      if (got.minor != want.minor)
        report($sformatf("minor expected %0d, got %0d", want.minor, got.minor));
      if (got.build != want.build)
        report($sformatf("build expected %0d, got %0d", want.build, got.build));
      if (got.revision != want.revision)
        report($sformatf("revision expected %0d, got %0d", want.revision, got.revision));
      if (got.part_count != want.part_count)
        report($sformatf("part_count expected %0d, got %0d", want.part_count,
                         got.part_count));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Signals of the block.
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               present;
  logic [CHAR_W-1:0]  ch;
  logic               last;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [PART_W-1:0]  major;
  logic [PART_W-1:0]  minor;
  logic [PART_W-1:0]  build;
  logic [PART_W-1:0]  revision;
  logic [COUNT_W-1:0] part_count;

  // Traffic shaping, set by the main sequence between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int held_cycles    = 0;

  // Run statistics for the summary.
  int chars_sent   = 0;
  int strings_sent = 0;

  version_checker chk = new();

  dotted_version_string_parser DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .present    (present),
    .ch         (ch),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .major      (major),
    .minor      (minor),
    .build      (build),
    .revision   (revision),
    .part_count (part_count)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Monitor. Handshake signals are read right at the rising edge, before any
  // nonblocking update of that edge lands, so they hold the values that the
  // block itself sees at this edge. A result can never leave in the same cycle
  // as the transfer that caused it, so checking before noting is safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        chk.check_version({status_t'(status), major, minor, build, revision, part_count});
      if (in_valid && !in_stall)
        chk.note_transfer(present, ch, last);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Each cycle it stalls with the probability of the current phase.
  // When a hold-off is requested it keeps the stall up without a break, tracking its
  // length in held_cycles against HOLD_CYCLES, so that the result register fills and the block has to push
  // back on its input while the sender keeps offering characters.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held_cycles  = 0;
        while (held_cycles < HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
          held_cycles++;
        end
      end
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks.
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is taken. Idle cycles are
  // inserted in front of the item with the probability of the current phase.
  // The payload is only changed when a new item is offered, never while stalled.
  task automatic send_item(input logic p, input logic [CHAR_W-1:0] c, input logic l);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    present  <= p;
    ch       <= c;
    last     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  // Sends a whole string. The end mark rides on the final character, or on a
  // separate item without a character when bare_end is set or the string is
  // empty. Items with neither a character nor the end mark are mixed in with
  // the given probability; the block must ignore them.
  task automatic send_text(input text_t txt, input bit bare_end, input int ignore_pct);
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(99, 0) < ignore_pct) send_item(1'b0, 8'($urandom), 1'b0);
      send_item(1'b1, txt[i], !bare_end && i == txt.size() - 1);
    end
    if (bare_end || txt.size() == 0) send_item(1'b0, 8'($urandom), 1'b1);
    strings_sent++;
  endtask

  // Stops offering and waits until every expected result has been taken. The
  // first edge lets the monitor note the transfer taken at the current edge.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.expected_versions.size() != 0) @(posedge clk);
  endtask

  function automatic text_t to_bytes(string s);
    text_t t;
    for (int i = 0; i < s.len(); i++) t.insert(t.size(), s[i]);
    return t;
  endfunction

  // One decimal part. Short values dominate; the rest reach the full 31-bit
  // range, sit right at the overflow boundary, carry leading zeros, or are
  // digit runs long enough to overflow well past the limit.
  function automatic string random_part();
    longint boundary;
    string  s;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: s = $sformatf("%0d", $urandom_range(99, 0));
      5:             s = $sformatf("%0d", $urandom_range(99999, 100));
      6:             s = $sformatf("%0d", $urandom_range(2147483647, 0));
      7: begin
        boundary = 64'd2147483644 + $urandom_range(7, 0);
        s = $sformatf("%0d", boundary);
      end
      8:             s = {"00", $sformatf("%0d", $urandom_range(999, 0))};
      default: begin
        s = "9";
        repeat ($urandom_range(12, 10)) s = {s, $sformatf("%0d", $urandom_range(9, 0))};
      end
    endcase
    return s;
  endfunction

  // One random string. Most are well-formed so that the deeper states (three
  // and four parts, large values) are reached; the rest are well-formed strings
  // with one byte replaced, broken dot structure (single part, five or six
  // parts, an empty part anywhere), empty strings and byte noise.
  function automatic text_t random_text();
    text_t t;
    string s;
    int    kind;
    int    parts;
    int    hole;
    kind = $urandom_range(99, 0);
    s    = "";
    if (kind < 89) begin
      parts = (kind < 79) ? $urandom_range(4, 2) : $urandom_range(6, 1);
      hole  = (kind >= 79 && parts >= 2 && parts <= 4) ? $urandom_range(parts - 1, 0) : -1;
      for (int p = 0; p < parts; p++) begin
        if (p != 0) s = {s, "."};
        if (p != hole) s = {s, random_part()};
      end
      t = to_bytes(s);
      if (kind >= 72 && kind < 79) t[$urandom_range(t.size() - 1, 0)] = 8'($urandom);
    end else if (kind >= 94) begin
      repeat ($urandom_range(8, 1)) begin
        case ($urandom_range(3, 0))
          0:       t.insert(t.size(), 8'($urandom));
          1:       t.insert(t.size(), CH_DOT);
          default: t.insert(t.size(), 8'(CH_ZERO + $urandom_range(9, 0)));
        endcase
      end
    end
    return t;
  endfunction

  // Random strings until the phase has sent its share of transfers, then a
  // pause until all of its results are back.
  task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                  input int item_goal);
    int    start_count;
    text_t txt;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count    = chars_sent;
    while (chars_sent - start_count < item_goal) begin
      txt = random_text();
      send_text(txt, $urandom_range(9, 0) == 0, 4);
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    text_t odd;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    present  <= 1'b0;
    ch       <= '0;
    last     <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed strings: end of string with no characters, the largest value in
    // every part, all zeros, leading zeros, each kind of format error, and
    // overflow in the first and in the last part.
    send_text(to_bytes(""), 1'b1, 0);
    send_text(to_bytes("2147483647.2147483647.2147483647.2147483647"), 1'b0, 0);
    send_text(to_bytes("0.0.0.0"), 1'b0, 0);
    send_text(to_bytes("0002147483647.010.3"), 1'b0, 0);
    send_text(to_bytes("1.2.3"), 1'b1, 0);
    send_text(to_bytes("2147483648.1"), 1'b0, 0);
    send_text(to_bytes("1.99999999999"), 1'b0, 0);
    send_text(to_bytes("17"), 1'b0, 0);
    send_text(to_bytes(".1"), 1'b0, 0);
    send_text(to_bytes("1."), 1'b0, 0);
    send_text(to_bytes("1..2"), 1'b0, 0);
    send_text(to_bytes("1.2.3.4.5"), 1'b0, 0);
    send_text(to_bytes("1/2"), 1'b0, 0);
    send_text(to_bytes("1.:"), 1'b0, 0);

    // Bytes outside the printable range, NUL and the top bit among them.
    odd = {8'h31, CH_DOT, 8'h00, 8'hFF};
    send_text(odd, 1'b0, 0);
    odd = {8'h80, 8'h31, CH_DOT, 8'h32};
    send_text(odd, 1'b1, 0);

    // Items without a character and without the end mark, both between strings
    // and inside one; none of them may disturb the parse.
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b1, "4", 1'b0);
    send_item(1'b0, 8'hA5, 1'b0);
    send_item(1'b1, CH_DOT, 1'b0);
    send_item(1'b1, "7", 1'b0);
    send_item(1'b0, 8'h5A, 1'b1);
    strings_sent++;
    wait_for_results();

    // Random phases. The first runs with no idling at all and with a long
    // receiver hold-off, so the block fills and stalls its input. Every phase
    // ends with the sender paused until all results are back.
    hold_request = 1'b1;
    run_random_phase(0, 0, 290);
    run_random_phase(47, 0, 290);
    run_random_phase(0, 47, 290);
    run_random_phase(6, 6, 290);

    // Let the pipeline run dry; any late result now shows up as unexpected.
    repeat (10) @(posedge clk);
    if (chk.expected_versions.size() != 0)
      chk.report($sformatf("%0d results never arrived", chk.expected_versions.size()));

    $display("Sent %0d strings in %0d transfers across idle-free, sender-idle,",
             strings_sent, chars_sent);
    $display("receiver-stall and mixed phases with a %0d-cycle hold-off; %0s",
             HOLD_CYCLES, $sformatf("%0d ok, %0d empty, %0d format results.",
                                    chk.ok_seen, chk.empty_seen, chk.format_seen));
    if (chk.mismatches == 0)
      $display("dotted_version_string_parser test passed");
    else
      $display("dotted_version_string_parser test failed");
    $finish;
  end

  // Watchdog. A correct run needs well under a twentieth of this time.
  initial begin
    #3000000;
    $display("Timeout: results still outstanding or input never accepted.");
    $display("dotted_version_string_parser test failed");
    $finish;
  end

endmodule
